// ----- rtl/char_lcd_bus_sequencer_defines.svh -----
// Assertion macros used by the character LCD bus sequencer checker.
// Depends on nothing; include by bare file name.
`ifndef CHAR_LCD_BUS_SEQUENCER_DEFINES_SVH
`define CHAR_LCD_BUS_SEQUENCER_DEFINES_SVH

// Same-cycle implication, disabled while reset is asserted.
`define CLBS_ASSERT_IMPL(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
		else $error("clbs check failed");

// Next-cycle implication, disabled while reset is asserted.
`define CLBS_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
		else $error("clbs check failed");

`endif

// ----- rtl/clbs_pkg.sv -----
// Package for the character LCD bus sequencer: action codes, bus phases,
// command constants and the structs shared by the RTL files. No dependencies.
`default_nettype none

package clbs_pkg;

	localparam int QDEPTH    = 4;
	localparam int ACTION_W  = 3;
	localparam int BYTE_W    = 8;
	localparam int COL_W     = 6;
	localparam int COUNT_W   = 3;
	localparam int CFG_IDX_W = 3;

	// request codes
	localparam logic [ACTION_W-1:0] ACT_TICK    = 3'd0;
	localparam logic [ACTION_W-1:0] ACT_INIT    = 3'd1;
	localparam logic [ACTION_W-1:0] ACT_CMD     = 3'd2;
	localparam logic [ACTION_W-1:0] ACT_DATA    = 3'd3;
	localparam logic [ACTION_W-1:0] ACT_SET_POS = 3'd4;

	// configuration register indexes
	localparam logic [CFG_IDX_W-1:0] CFG_DISPLAY_ON   = 3'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_CURSOR_ON    = 3'd1;
	localparam logic [CFG_IDX_W-1:0] CFG_BLINK_ON     = 3'd2;
	localparam logic [CFG_IDX_W-1:0] CFG_ADDR_INC     = 3'd3;
	localparam logic [CFG_IDX_W-1:0] CFG_SCREEN_SHIFT = 3'd4;

	// controller command bytes
	localparam logic [BYTE_W-1:0] CMD_FUNC_SET  = 8'h38;
	localparam logic [BYTE_W-1:0] CMD_DISP_CTRL = 8'h08;
	localparam logic [BYTE_W-1:0] CMD_ENTRY     = 8'h04;
	localparam logic [BYTE_W-1:0] CMD_CLEAR     = 8'h01;
	localparam logic [BYTE_W-1:0] CMD_DDRAM     = 8'h80;
	localparam logic [BYTE_W-1:0] ROW1_BASE     = 8'h40;
	localparam logic [BYTE_W-1:0] POLL_BUS      = 8'hFF;

	localparam logic [COUNT_W-1:0] COUNT_ONE  = 3'd1;
	localparam logic [COUNT_W-1:0] COUNT_FULL = 3'(QDEPTH);

	typedef enum logic [5:0] {
		PH_IDLE  = 6'b000001,
		PH_START = 6'b000010,
		PH_POLL  = 6'b000100,
		PH_SETUP = 6'b001000,
		PH_EN_HI = 6'b010000,
		PH_EN_LO = 6'b100000
	} phase_t;

	typedef struct packed {
		logic              en;
		logic              rw;
		logic              rs;
		logic [BYTE_W-1:0] db;
	} pins_t;

	typedef struct packed {
		logic              rs;
		logic [BYTE_W-1:0] data;
	} entry_t;

	typedef entry_t [QDEPTH-1:0] queue_t;

	typedef struct packed {
		logic display_on;
		logic cursor_on;
		logic blink_on;
		logic address_increment;
		logic screen_shift;
	} cfg_t;

	typedef struct packed {
		logic [COUNT_W-1:0] count;
		phase_t             phase;
		pins_t              pins;
	} ctrl_t;

	typedef struct packed {
		logic [ACTION_W-1:0] action;
		logic [BYTE_W-1:0]   byte_value;
		logic [COL_W-1:0]    column;
		logic                row;
		logic                busy_line;
	} req_t;

	typedef struct packed {
		pins_t pins;
		logic  idle;
		logic  rejected;
	} res_t;

endpackage

`default_nettype wire

// ----- rtl/clbs_req_if.sv -----
// Request channel of the character LCD bus sequencer: valid, ready, payload.
// Depends on clbs_pkg.
`default_nettype none

interface clbs_req_if
	import clbs_pkg::*;
();
	logic                valid;
	logic                ready;
	logic [ACTION_W-1:0] action;
	logic [BYTE_W-1:0]   byte_value;
	logic [COL_W-1:0]    column;
	logic                row;
	logic                busy_line;

	modport source (output valid, action, byte_value, column, row, busy_line, input ready);
	modport sink   (input valid, action, byte_value, column, row, busy_line, output ready);
endinterface

`default_nettype wire

// ----- rtl/clbs_res_if.sv -----
// Result channel of the character LCD bus sequencer: valid, ready, pin levels
// and status. Depends on clbs_pkg.
`default_nettype none

interface clbs_res_if
	import clbs_pkg::*;
();
	logic              valid;
	logic              ready;
	logic [BYTE_W-1:0] bus_data;
	logic              reg_select;
	logic              read_write;
	logic              enable_pin;
	logic              idle;
	logic              rejected;

	modport source (output valid, bus_data, reg_select, read_write, enable_pin, idle, rejected,
		input ready);
	modport sink   (input valid, bus_data, reg_select, read_write, enable_pin, idle, rejected,
		output ready);
endinterface

`default_nettype wire

// ----- rtl/clbs_step.sv -----
// Next-state logic of the bus sequencer: queue loading, phase advance and the
// result of one transaction. Purely combinational. Depends on clbs_pkg.
`default_nettype none

module clbs_step
	import clbs_pkg::*;
(
	input  req_t   req,
	input  cfg_t   cfg,
	input  ctrl_t  ctrl_cur,
	input  queue_t queue_cur,
	output ctrl_t  ctrl_nxt,
	output queue_t queue_nxt,
	output res_t   res
);

	logic              rejected;
	logic [BYTE_W-1:0] pos_addr;
	logic [COUNT_W-1:0] count_dec;

	assign pos_addr  = ({1'b0, req.row, 6'b0} + {2'b0, req.column}) | CMD_DDRAM;
	assign count_dec = (ctrl_cur.count != '0) ? ctrl_cur.count - COUNT_ONE : ctrl_cur.count;

	always_comb begin
		ctrl_nxt  = ctrl_cur;
		queue_nxt = queue_cur;
		rejected  = 1'b0;
		case (req.action) inside
			ACT_TICK: begin
				unique case (ctrl_cur.phase)
					PH_START: begin
						ctrl_nxt.pins  = '{en: 1'b1, rw: 1'b1, rs: 1'b0, db: POLL_BUS};
						ctrl_nxt.phase = PH_POLL;
					end
					PH_POLL: begin
						// hold the poll while the controller reports busy
						if (!req.busy_line) begin
							ctrl_nxt.pins.en = 1'b0;
							ctrl_nxt.phase   = PH_SETUP;
						end
					end
					PH_SETUP: begin
						ctrl_nxt.pins  = '{en: 1'b0, rw: 1'b0, rs: queue_cur[0].rs,
							db: queue_cur[0].data};
						ctrl_nxt.phase = PH_EN_HI;
					end
					PH_EN_HI: begin
						ctrl_nxt.pins.en = 1'b1;
						ctrl_nxt.phase   = PH_EN_LO;
					end
					PH_EN_LO: begin
						ctrl_nxt.pins.en = 1'b0;
						for (int i = 0; i < QDEPTH - 1; i++) begin
							queue_nxt[i] = queue_cur[i+1];
						end
						queue_nxt[QDEPTH-1] = '0;
						ctrl_nxt.count = count_dec;
						ctrl_nxt.phase = (count_dec != '0) ? PH_START : PH_IDLE;
					end
					default: begin
						ctrl_nxt.phase = PH_IDLE;
					end
				endcase
			end
			ACT_INIT, ACT_CMD, ACT_DATA, ACT_SET_POS: begin
				if (ctrl_cur.count != '0) begin
					rejected = 1'b1;
				end else begin
					ctrl_nxt.phase = PH_START;
					ctrl_nxt.count = COUNT_ONE;
					case (req.action)
						ACT_INIT: begin
							queue_nxt[0] = '{rs: 1'b0, data: CMD_FUNC_SET};
							queue_nxt[1] = '{rs: 1'b0, data: CMD_DISP_CTRL |
								{5'b0, cfg.display_on, cfg.cursor_on, cfg.blink_on}};
							queue_nxt[2] = '{rs: 1'b0, data: CMD_ENTRY |
								{6'b0, cfg.address_increment, cfg.screen_shift}};
							queue_nxt[3] = '{rs: 1'b0, data: CMD_CLEAR};
							ctrl_nxt.count = COUNT_FULL;
						end
						ACT_CMD:  queue_nxt[0] = '{rs: 1'b0, data: req.byte_value};
						ACT_DATA: queue_nxt[0] = '{rs: 1'b1, data: req.byte_value};
						default:  queue_nxt[0] = '{rs: 1'b0, data: pos_addr};
					endcase
				end
			end
			default: begin
				// unused codes leave everything alone
			end
		endcase
	end

	assign res.pins     = ctrl_nxt.pins;
	assign res.idle     = (ctrl_nxt.count == '0);
	assign res.rejected = rejected;

endmodule

`default_nettype wire

// ----- rtl/char_lcd_bus_sequencer.sv -----
// Character LCD bus sequencer, 8-bit parallel bus: one request or tick in,
// one pin-level result out per transaction. Throughput is one transaction per
// clock; a result appears in the output register the cycle after its request
// is taken, and the request side stays ready while that register is empty or
// being drained. Each tick moves the byte at the head of a four-entry queue one
// bus phase on (start, busy poll, setup, enable high, enable low; a busy poll
// holds); requests are taken only with the queue empty, else flagged rejected.
// Write configuration only between transactions.
// Depends on clbs_pkg, clbs_req_if, clbs_res_if and clbs_step.
`default_nettype none

module char_lcd_bus_sequencer
	import clbs_pkg::*;
(
	input  wire                 clk,
	input  wire                 arst_n,
	input  wire                 cfg_wr_en,
	input  wire [CFG_IDX_W-1:0] cfg_index,
	input  wire                 cfg_data,
	clbs_req_if.sink            req,
	clbs_res_if.source          res
);

	cfg_t   cfg_q;
	ctrl_t  ctrl_q;
	ctrl_t  ctrl_nxt;
	queue_t queue_q;
	queue_t queue_nxt;
	req_t   req_in;
	res_t   res_nxt;
	res_t   res_q;
	logic   res_valid_q;
	logic   req_fire;

	assign req.ready = !res_valid_q || res.ready;
	assign req_fire  = req.valid && req.ready;

	assign req_in = '{action: req.action, byte_value: req.byte_value, column: req.column,
		row: req.row, busy_line: req.busy_line};

	clbs_step u_step (
		.req       (req_in),
		.cfg       (cfg_q),
		.ctrl_cur  (ctrl_q),
		.queue_cur (queue_q),
		.ctrl_nxt  (ctrl_nxt),
		.queue_nxt (queue_nxt),
		.res       (res_nxt)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q <= '{display_on: 1'b1, cursor_on: 1'b0, blink_on: 1'b0,
				address_increment: 1'b1, screen_shift: 1'b0};
		end else if (cfg_wr_en) begin
			unique case (cfg_index)
				CFG_DISPLAY_ON:   cfg_q.display_on        <= cfg_data;
				CFG_CURSOR_ON:    cfg_q.cursor_on         <= cfg_data;
				CFG_BLINK_ON:     cfg_q.blink_on          <= cfg_data;
				CFG_ADDR_INC:     cfg_q.address_increment <= cfg_data;
				CFG_SCREEN_SHIFT: cfg_q.screen_shift      <= cfg_data;
				default: begin
					// drop writes beyond the register list
				end
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ctrl_q <= '{count: '0, phase: PH_IDLE, pins: '0};
		end else if (req_fire) begin
			ctrl_q <= ctrl_nxt;
		end
	end

	// queue contents are only read below the fill count
	always_ff @(posedge clk) begin
		if (req_fire) begin
			queue_q <= queue_nxt;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			res_valid_q <= 1'b0;
		end else if (req_fire) begin
			res_valid_q <= 1'b1;
		end else if (res.ready) begin
			res_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (req_fire) begin
			res_q <= res_nxt;
		end
	end

	assign res.valid      = res_valid_q;
	assign res.bus_data   = res_q.pins.db;
	assign res.reg_select = res_q.pins.rs;
	assign res.read_write = res_q.pins.rw;
	assign res.enable_pin = res_q.pins.en;
	assign res.idle       = res_q.idle;
	assign res.rejected   = res_q.rejected;

endmodule

`default_nettype wire

// ----- rtl/clbs_checker.sv -----
// Port-level checks for the character LCD bus sequencer, bound to the top level.
// Depends on clbs_pkg and char_lcd_bus_sequencer_defines.svh.
`default_nettype none
`include "char_lcd_bus_sequencer_defines.svh"

module clbs_checker
	import clbs_pkg::*;
(
	input wire              clk,
	input wire              arst_n,
	input wire              res_valid,
	input wire              res_ready,
	input wire [BYTE_W-1:0] bus_data,
	input wire              reg_select,
	input wire              read_write,
	input wire              enable_pin,
	input wire              idle,
	input wire              rejected
);

	// a dropped request always finds bytes still pending
	`CLBS_ASSERT_IMPL(a_reject_busy, clk, arst_n, res_valid && rejected, !idle)

	// read cycles only happen during the busy poll
	`CLBS_ASSERT_IMPL(a_poll_pins, clk, arst_n, res_valid && read_write,
		bus_data == POLL_BUS && !reg_select)

	// the last byte finishes with the strobe low
	`CLBS_ASSERT_IMPL(a_idle_strobe, clk, arst_n, res_valid && idle, !enable_pin)

	`CLBS_ASSERT_NEXT(a_res_hold, clk, arst_n, res_valid && !res_ready,
		res_valid && $stable(bus_data) && $stable(reg_select) && $stable(read_write) &&
		$stable(enable_pin) && $stable(idle) && $stable(rejected))

endmodule

bind char_lcd_bus_sequencer clbs_checker u_clbs_checker (
	.clk        (clk),
	.arst_n     (arst_n),
	.res_valid  (res.valid),
	.res_ready  (res.ready),
	.bus_data   (res.bus_data),
	.reg_select (res.reg_select),
	.read_write (res.read_write),
	.enable_pin (res.enable_pin),
	.idle       (res.idle),
	.rejected   (res.rejected)
);

`default_nettype wire
